>>> hw/rtl/rqnh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqnh_pkg: shared types for the ray/quad nearest-hit block
// Item payload structs and the format constants used by the datapath.
// ----------------------------------------------------------------------------
package rqnh_pkg;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef struct packed {
    logic        req_type;
    logic [47:0] ray_origin;
    logic [47:0] ray_dir;
    logic [47:0] quad_normal;
    logic [47:0] vert0;
    logic [47:0] vert1;
    logic [47:0] vert2;
    logic [47:0] vert3;
    logic [2:0]  vert_count;
    logic        last_quad;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [9:0]  hit_index;
    logic [16:0] hit_t;
    logic [47:0] hit_normal;
  } out_item_t;

  // Request codes.
  localparam logic REQ_RAY  = 1'b0;
  localparam logic REQ_QUAD = 1'b1;

  // Signed 16-bit component k of a packed vector.
  function automatic logic signed [15:0] comp(input logic [47:0] v, input logic [1:0] k);
    logic signed [15:0] r;
    unique case (k)
      2'd0:    r = v[15:0];
      2'd1:    r = v[31:16];
      default: r = v[47:32];
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/rqnh_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqnh_div: restoring divider
// Unsigned 56 / 40 bit division, one quotient bit per cycle, truncated
// quotient saturated at 17 bits (callers compare it against the best t).
// ----------------------------------------------------------------------------
module rqnh_div import rqnh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [55:0] dividend,
  input  logic [39:0] divisor,
  output logic        done,
  output logic [16:0] quotient
);

  logic [40:0] rem;
  logic [55:0] shreg;
  logic [55:0] quo;
  logic [5:0]  cnt;
  logic        busy;
  logic [40:0] trial;
  logic [40:0] rem_shift;

  // One restoring step per cycle.
  always_comb begin
    rem_shift = {rem[39:0], shreg[55]};
    trial     = rem_shift - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= 6'd56;
        rem   <= '0;
        shreg <= dividend;
        quo   <= '0;
      end else if (busy) begin
        shreg <= {shreg[54:0], 1'b0};
        if (!trial[40]) begin
          rem <= trial;
          quo <= {quo[54:0], 1'b1};
        end else begin
          rem <= rem_shift;
          quo <= {quo[54:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = (|quo[55:17]) ? 17'h1FFFF : quo[16:0];

endmodule

>>> hw/rtl/ray_quad_nearest_hit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_quad_nearest_hit: nearest hit of a ray over a stream of polygons
// Sequenced datapath around one shared multiplier and a serial divider.
// ----------------------------------------------------------------------------
// Usage: send a ray item (req_type 0) to set the ray and start a search, then
// one quad item per polygon. The item carrying last_quad produces one result
// item with the nearest hit, its arrival index, t and normal; the search then
// restarts along the same ray.
// Channels: in_valid/in_stall and out_valid/out_stall; an item moves when
// valid is high and stall is low.
// Sequencing: a ray item is taken while idle and produces nothing. A quad
// item holds in_stall high through the n.dir multiplies and a closing state
// when it faces away from the ray, through the n.v0 - n.o multiplies as well
// when t is negative, through serial division too when t is not below the
// best so far, and through the hit point, axis choice and crossing test for
// a candidate with three or four vertices. A quad carrying last_quad then
// enters the emit state, which waits while a stalled result still holds the
// output register; a new item is taken only after the previous one is done.
// Reset clears the ray, the best hit and the quad counter.
// A stalled result is held in the output register; the next item is still
// processed, and a later result waits until the register is free.
// ----------------------------------------------------------------------------
module ray_quad_nearest_hit import rqnh_pkg::*; #(
  parameter int MAX_QUADS = 1024
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int CW = (MAX_QUADS > 1) ? $clog2(MAX_QUADS) : 1;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DEN   = 10'b0000000010,
    S_NUM   = 10'b0000000100,
    S_DIV   = 10'b0000001000,
    S_WAIT  = 10'b0000010000,
    S_PNT   = 10'b0000100000,
    S_AXIS  = 10'b0001000000,
    S_CROSS = 10'b0010000000,
    S_DONE  = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  state_t state;
  in_item_t item;
  logic [47:0] origin_reg, direction_reg;
  logic [16:0] best_t;
  logic        best_hit;
  logic [9:0]  best_index;
  logic [47:0] best_normal;
  logic [CW-1:0] quad_counter;
  logic [CW-1:0] cur_index;

  logic [2:0]  step;
  logic signed [39:0] acc;
  logic signed [39:0] den;
  logic signed [15:0] ma, mb;
  logic signed [31:0] prod;
  logic [16:0] tq;
  logic signed [16:0] pnt [3];
  logic [1:0]  u_ax, v_ax;
  logic        parity;
  logic signed [17:0] dx2, dy2;
  logic        xs2, ys2;
  logic        div_start, div_done;
  logic [16:0] div_q;
  logic signed [39:0] num_neg;

  // Shared multiplier.
  assign prod = ma * mb;

  // Operand selection for the multiplier per state and step.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_DEN: begin
        ma = comp(item.quad_normal, step[1:0]);
        mb = comp(direction_reg, step[1:0]);
      end
      S_NUM: begin
        ma = comp(item.quad_normal, step[1:0]);
        mb = step[2] ? comp(origin_reg, step[1:0]) : comp(item.vert0, step[1:0]);
      end
      S_PNT: begin
        ma = comp(direction_reg, step[1:0]);
        mb = $signed({1'b0, tq[14:0]});
      end
      default: ;
    endcase
  end

  // Numerator of t is negative of (n.v0 - n.o), kept non-negative.
  assign num_neg = -acc;

  rqnh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({num_neg[39:0], 16'h0}),
    .divisor  (-den),
    .done     (div_done),
    .quotient (div_q)
  );

  // Crossing-test vertex for the current step (walks nv-1 down to 0).
  logic [47:0] cv;
  logic signed [17:0] dx1, dy1;
  logic        xs1, ys1;
  logic signed [35:0] c_l, c_r;
  logic        flip;
  logic        nv4;

  assign nv4 = (item.vert_count >= 3'd4);

  always_comb begin
    unique case (step[1:0])
      2'd0:    cv = item.vert0;
      2'd1:    cv = item.vert1;
      2'd2:    cv = item.vert2;
      default: cv = item.vert3;
    endcase
    dx1 = 18'(comp(cv, u_ax)) - 18'(pnt[u_ax]);
    dy1 = 18'(comp(cv, v_ax)) - 18'(pnt[v_ax]);
    xs1 = dx1 > 0;
    ys1 = dy1 > 0;
    c_l = dx2 * dy1;
    c_r = dx1 * dy2;
    flip = 1'b0;
    if (ys1 != ys2) begin
      if (xs1 != xs2) flip = (c_l > c_r) ^ (dy2 > dy1);
      else flip = xs1;
    end
  end

  logic signed [16:0] ax, ay, az;
  logic signed [40:0] pfull;
  logic [15:0]        tfrac;

  always_comb begin
    ax = 17'(comp(item.quad_normal, 2'd0));
    ay = 17'(comp(item.quad_normal, 2'd1));
    az = 17'(comp(item.quad_normal, 2'd2));
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    if (az < 0) az = -az;
    // Hit point: origin*2^16 + dir*t, t split as bit16, bit15 and low 15 bits.
    tfrac = tq[15:0];
    pfull = (41'(comp(origin_reg, step[1:0])) <<< 16)
          + (tq[16] ? (41'(comp(direction_reg, step[1:0])) <<< 16) : 41'sd0)
          + 41'(prod) + (tfrac[15] ? (41'(comp(direction_reg, step[1:0])) <<< 15) : 41'sd0);
  end

  assign in_stall  = (state != S_IDLE);
  assign div_start = (state == S_DIV);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      origin_reg   <= '0;
      direction_reg <= '0;
      best_t       <= ONE_Q16;
      best_hit     <= 1'b0;
      best_index   <= '0;
      best_normal  <= '0;
      quad_counter <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            if (in_data.req_type == REQ_RAY) begin
              origin_reg    <= in_data.ray_origin;
              direction_reg <= in_data.ray_dir;
              best_t        <= ONE_Q16;
              best_hit      <= 1'b0;
              best_index    <= '0;
              best_normal   <= '0;
              quad_counter  <= '0;
            end else begin
              cur_index    <= quad_counter;
              quad_counter <= (32'(quad_counter) == MAX_QUADS - 1) ? '0
                              : quad_counter + CW'(1);
              step  <= '0;
              acc   <= '0;
              state <= S_DEN;
            end
          end
        end
        S_DEN: begin
          acc  <= acc + 40'(prod);
          step <= step + 3'd1;
          if (step == 3'd2) begin
            den   <= acc + 40'(prod);
            acc   <= '0;
            step  <= '0;
            state <= ((acc + 40'(prod)) >= 0) ? S_DONE : S_NUM;
          end
        end
        S_NUM: begin
          acc  <= step[2] ? acc - 40'(prod) : acc + 40'(prod);
          step <= (step == 3'd2) ? 3'd4 : step + 3'd1;
          if (step == 3'd6) begin
            acc   <= acc - 40'(prod);
            state <= ((acc - 40'(prod)) > 0) ? S_DONE : S_DIV;
          end
        end
        S_DIV: state <= S_WAIT;
        S_WAIT: begin
          if (div_done) begin
            tq   <= div_q;
            step <= '0;
            state <= ({15'b0, div_q} >= 32'(best_t)) ? S_DONE : S_PNT;
          end
        end
        S_PNT: begin
          pnt[step[1:0]] <= pfull[32:16];
          step <= step + 3'd1;
          if (step == 3'd2) state <= S_AXIS;
        end
        S_AXIS: begin
          if (ax > ay && ax > az) begin
            u_ax <= 2'd1; v_ax <= 2'd2;
          end else if (ay > ax && ay > az) begin
            u_ax <= 2'd2; v_ax <= 2'd0;
          end else begin
            u_ax <= 2'd0; v_ax <= 2'd1;
          end
          step  <= 3'd0;
          parity <= 1'b0;
          state <= S_CROSS;
        end
        S_CROSS: begin
          if (step[2]) begin
            // Walk the edges from vertex nv-1 down to vertex 0.
            parity <= parity ^ flip;
            if (ys1 != ys2) ys2 <= ys1;
            xs2 <= xs1; dx2 <= dx1; dy2 <= dy1;
            if (step[1:0] == 2'd0) state <= S_DONE;
            step <= {1'b1, step[1:0] - 2'd1};
          end else begin
            // Load reference from vertex 0, then start at nv-1.
            dx2 <= dx1; dy2 <= dy1; xs2 <= xs1; ys2 <= ys1;
            step <= nv4 ? 3'b111 : 3'b110;
          end
        end
        S_DONE: begin
          state <= item.last_quad ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid          <= 1'b1;
            out_data.hit       <= best_hit;
            out_data.hit_index <= best_hit ? best_index : 10'd0;
            out_data.hit_t     <= best_t;
            out_data.hit_normal <= best_hit ? best_normal : 48'd0;
            best_t      <= ONE_Q16;
            best_hit    <= 1'b0;
            best_index  <= '0;
            best_normal <= '0;
            quad_counter <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // Record a hit when the crossing walk ends with odd parity.
      if (state == S_CROSS && step[2] && step[1:0] == 2'd0 && (parity ^ flip)) begin
        best_t      <= tq;
        best_hit    <= 1'b1;
        best_index  <= 10'(cur_index);
        best_normal <= item.quad_normal;
      end
      if (state != S_IDLE && state != S_CROSS && state != S_AXIS) parity <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_hit_t: assert property (@(posedge clk) disable iff (rst)
    best_hit |-> (best_t < ONE_Q16)) else $error("hit without t below 1.0");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(out_data)) else $error("result changed");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.hit) |-> (out_data.hit_t == ONE_Q16))
    else $error("miss with t");
`endif

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for ray_quad_nearest_hit
// Rays and quad streams go in, and each quad stream's nearest-hit result is
// compared field by field with a predictor that keeps its own ray and best
// hit. Both channels idle at random, and at one point the result side holds
// off for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import rqnh_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int IN_W           = $bits(in_item_t);

  // Scoreboard: predicts nearest hits and holds the results still due.
  class hit_scoreboard;
    logic [47:0] ray_org;
    logic [47:0] ray_vec;
    logic [16:0] near_t;
    logic        near_hit;
    logic [9:0]  near_idx;
    logic [47:0] near_nrm;
    logic [9:0]  quad_cnt;
    out_item_t   due_q[$];
    int          errors;
    int          results_seen;
    int          hits_seen;

    function void clear_search();
      near_t   = ONE_Q16;
      near_hit = 1'b0;
      near_idx = '0;
      near_nrm = '0;
      quad_cnt = '0;
    endfunction

    function void reset_state();
      ray_org = '0;
      ray_vec = '0;
      clear_search();
    endfunction

    function longint part(logic [47:0] v, int k);
      logic signed [15:0] s;
      s = v[16*k +: 16];
      return longint'(s);
    endfunction

    function longint dotp(logic [47:0] a, logic [47:0] b);
      return part(a, 0) * part(b, 0) + part(a, 1) * part(b, 1) + part(a, 2) * part(b, 2);
    endfunction

    // Floor division by 65536 on a signed value.
    function longint floor16(longint v);
      return v >>> 16;
    endfunction

    // Tests one quad against the stored ray and updates the nearest hit.
    function void test_quad(in_item_t it, logic [9:0] idx);
      logic [47:0] vx[4];
      int     nv, u, v, j;
      longint den, num, tq, ax, ay, az;
      longint pt[3];
      longint dx1, dy1, dx2, dy2;
      bit     xs1, ys1, xs2, ys2, parity;
      vx[0] = it.vert0;
      vx[1] = it.vert1;
      vx[2] = it.vert2;
      vx[3] = it.vert3;
      nv = (it.vert_count >= 3'd4) ? 4 : 3;
      parity = 0;
      den = dotp(it.quad_normal, ray_vec);
      if (den >= 0) return;
      num = dotp(it.quad_normal, vx[0]) - dotp(it.quad_normal, ray_org);
      if (num > 0) return;
      tq = ((-num) <<< 16) / (-den);
      if (tq >= longint'(near_t)) return;
      for (int k = 0; k < 3; k++)
        pt[k] = floor16(part(ray_org, k) * 65536 + part(ray_vec, k) * tq);
      ax = part(it.quad_normal, 0); if (ax < 0) ax = -ax;
      ay = part(it.quad_normal, 1); if (ay < 0) ay = -ay;
      az = part(it.quad_normal, 2); if (az < 0) az = -az;
      if (ax > ay && ax > az) begin
        u = 1; v = 2;
      end else if (ay > ax && ay > az) begin
        u = 2; v = 0;
      end else begin
        u = 0; v = 1;
      end
      dx2 = part(vx[0], u) - pt[u];
      dy2 = part(vx[0], v) - pt[v];
      xs2 = dx2 > 0;
      ys2 = dy2 > 0;
      for (j = nv - 1; j >= 0; j--) begin
        dx1 = part(vx[j], u) - pt[u];
        dy1 = part(vx[j], v) - pt[v];
        xs1 = dx1 > 0;
        ys1 = dy1 > 0;
        if (ys1 != ys2) begin
          if (xs1 != xs2) begin
            if ((dx2 * dy1 > dx1 * dy2) ^ (dy2 > dy1)) parity = !parity;
          end else if (xs1) begin
            parity = !parity;
          end
          ys2 = ys1;
        end
        xs2 = xs1;
        dx2 = dx1;
        dy2 = dy1;
      end
      if (parity) begin
        near_t   = tq[16:0];
        near_hit = 1'b1;
        near_idx = idx;
        near_nrm = it.quad_normal;
      end
    endfunction

    // Notes an accepted input item.
    function void note_input(in_item_t it);
      logic [9:0] idx;
      out_item_t  r;
      if (it.req_type == REQ_RAY) begin
        ray_org = it.ray_origin;
        ray_vec = it.ray_dir;
        clear_search();
        return;
      end
      idx = quad_cnt;
      quad_cnt = quad_cnt + 10'd1;
      test_quad(it, idx);
      if (!it.last_quad) return;
      r.hit        = near_hit;
      r.hit_index  = near_hit ? near_idx : '0;
      r.hit_t      = near_t;
      r.hit_normal = near_hit ? near_nrm : '0;
      due_q.push_back(r);
      clear_search();
    endfunction

    // Checks an accepted result item against the oldest one due.
    task check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (due_q.size() == 0) begin
        report_err("result with none due", 0, 1);
        return;
      end
      want = due_q.pop_front();
      if (want.hit) hits_seen++;
      if (got.hit !== want.hit) report_err("hit", want.hit, got.hit);
      if (got.hit_index !== want.hit_index)
        report_err("hit_index", want.hit_index, got.hit_index);
      if (got.hit_t !== want.hit_t) report_err("hit_t", want.hit_t, got.hit_t);
      if (got.hit_normal !== want.hit_normal)
        report_err("hit_normal", want.hit_normal, got.hit_normal);
    endtask

    task report_err(string what, logic [63:0] want, logic [63:0] got);
      errors++;
      $display("%0t mismatch %s: expected %h, got %h", $realtime, what, want, got);
    endtask
  endclass

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  hit_scoreboard sb;
  int  idle_pct_in;
  int  idle_pct_out;
  bit  hold_results;
  bit  timed_out = 1'b0;
  int  quiet_cycles = 0;
  int  items_sent;

  ray_quad_nearest_hit u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Clock.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Watchdog on cycles with no item moving.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles > WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog expired with %0d results due", sb.due_q.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  // Result side: random stalls, a long hold when asked, checks on acceptance.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_results) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct_out);
    end
  end

  // Long hold-off on the result side, counted here.
  initial begin
    hold_results = 1'b0;
    wait (items_sent >= 300);
    @(posedge clk);
    hold_results = 1'b1;
    repeat (2000) @(posedge clk);
    hold_results = 1'b0;
  end

  function automatic logic [15:0] coord(int lo, int hi);
    return 16'($signed($urandom_range(hi - lo) + lo));
  endfunction

  // An item with every field random.
  function automatic in_item_t rand_item();
    return in_item_t'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom}));
  endfunction

  // Sends one item, holding it until accepted, with random idle cycles before.
  task automatic send(in_item_t it);
    while ($urandom_range(99) < idle_pct_in) begin
      in_valid <= 1'b0;
      in_data  <= rand_item();
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic send_ray(logic [47:0] org, logic [47:0] dir);
    in_item_t it;
    it = rand_item();
    it.req_type   = REQ_RAY;
    it.ray_origin = org;
    it.ray_dir    = dir;
    send(it);
  endtask

  task automatic send_quad(logic [47:0] nrm, logic [47:0] v0, logic [47:0] v1,
                           logic [47:0] v2, logic [47:0] v3, logic [2:0] cnt,
                           logic last);
    in_item_t it;
    it = rand_item();
    it.req_type    = REQ_QUAD;
    it.quad_normal = nrm;
    it.vert0       = v0;
    it.vert1       = v1;
    it.vert2       = v2;
    it.vert3       = v3;
    it.vert_count  = cnt;
    it.last_quad   = last;
    send(it);
  endtask

  // A square in the plane z = d facing a ray along -z, sized at random so
  // some quads catch the ray and others miss it.
  task automatic send_square(int d, bit last);
    int cx, cy, h;
    logic [15:0] z;
    cx = $urandom_range(1024) - 512;
    cy = $urandom_range(1024) - 512;
    h  = $urandom_range(1200) + 16;
    z  = 16'(d);
    send_quad({16'h4000 - 16'($urandom_range(1)), 16'($urandom_range(2)), 16'h0},
              {z, 16'(cy - h), 16'(cx - h)}, {z, 16'(cy - h), 16'(cx + h)},
              {z, 16'(cy + h), 16'(cx + h)}, {z, 16'(cy + h), 16'(cx - h)},
              $urandom_range(1) ? 3'd4 : 3'd3, last);
  endtask

  // A quad whose normal is dominated by x or y, so the other planes are used.
  task automatic send_side(bit last);
    int h;
    logic [15:0] q;
    h = $urandom_range(800) + 16;
    q = 16'($urandom_range(96) - 48);
    if ($urandom_range(1)) begin
      send_quad({16'h0, 16'h0, 16'hC000}, {16'(h), 16'(h), q}, {16'(-h), 16'(h), q},
                {16'(-h), 16'(-h), q}, {16'(h), 16'(-h), q}, 3'd4, last);
    end else begin
      send_quad({16'h0, 16'hC000, 16'h0}, {16'(h), q, 16'(h)}, {16'(-h), q, 16'(h)},
                {16'(-h), q, 16'(-h)}, {16'(h), q, 16'(-h)}, 3'($urandom_range(7)), last);
    end
  endtask

  // Stimulus.
  initial begin
    int n_quads;
    sb = new();
    sb.reset_state();
    sb.errors = 0;
    sb.results_seen = 0;
    sb.hits_seen = 0;
    items_sent   = 0;
    idle_pct_in  = 12;
    idle_pct_out = 12;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: quads before any ray, tied normal, extremes, odd vertex counts.
    send_quad('0, '0, '0, '0, '0, 3'd0, 1'b1);
    send_quad({16'h4000, 16'h4000, 16'h4000}, '0, '0, '0, '0, 3'd7, 1'b1);
    send_ray({16'hFC00, 16'h0, 16'h0}, {16'hF800, 16'h0, 16'h0});
    send_quad({16'hC000, 16'h0, 16'h0}, {16'hF800, 16'h0100, 16'h0100},
              {16'hF800, 16'h0100, 16'hFF00}, {16'hF800, 16'hFF00, 16'hFF00},
              {16'hF800, 16'hFF00, 16'h0100}, 3'd4, 1'b0);
    send_quad({16'h4000, 16'h0, 16'h0}, '0, '0, '0, '0, 3'd4, 1'b0);
    send_quad({16'hC000, 16'hC000, 16'hC000}, '0, '0, '0, '0, 3'd3, 1'b1);
    send_ray(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000);
    send_quad(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h8000_7FFF_8000,
              48'h7FFF_7FFF_8000, 48'h7FFF_8000_7FFF, 3'd4, 1'b0);
    send_quad(48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'h7FFF_8000_7FFF,
              48'h8000_8000_7FFF, 48'h8000_7FFF_8000, 3'd2, 1'b1);
    // Hit point beyond the 16-bit coordinate range, outside a full-range quad.
    send_ray({16'h0100, 16'h7000, 16'h7000}, {16'hFE00, 16'h7000, 16'h7000});
    send_quad({16'h4000, 16'h0, 16'h0}, {16'h0, 16'h8000, 16'h8000},
              {16'h0, 16'h8000, 16'h7FFF}, {16'h0, 16'h7FFF, 16'h7FFF},
              {16'h0, 16'h7FFF, 16'h8000}, 3'd4, 1'b1);
    send_ray({16'h0400, 16'h0010, 16'h0020}, {16'hF800, 16'h0, 16'h0});
    send_square(0, 1'b0);
    send_square(512, 1'b0);
    send_side(1'b0);
    send_square(-256, 1'b1);
    send_square(100, 1'b1);

    // Random: mostly well-formed objects, some noise quads and rays.
    while (items_sent < 700) begin
      if (items_sent > 450 && items_sent < 600) begin
        idle_pct_in  = 0;
        idle_pct_out = 0;
      end else begin
        idle_pct_in  = 12;
        idle_pct_out = 12;
      end
      case ($urandom_range(9))
        0: send_ray(48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
        1: send_quad(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                     48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                     48'({$urandom, $urandom}), 3'($urandom), 1'($urandom));
        default: begin
          send_ray({16'($urandom_range(2048)), coord(-64, 64), coord(-64, 64)},
                   {16'(-($urandom_range(2048) + 64)), coord(-16, 16), coord(-16, 16)});
          n_quads = $urandom_range(6) + 1;
          for (int q = 0; q < n_quads; q++) begin
            if ($urandom_range(3) == 0) send_side(q == n_quads - 1);
            else send_square($urandom_range(1536) - 512, q == n_quads - 1);
          end
        end
      endcase
    end
    in_valid <= 1'b0;

    while (sb.due_q.size() != 0 || hold_results) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d items sent, %0d results checked, %0d of them hits",
             items_sent, sb.results_seen, sb.hits_seen);
    $display("rays, quad streams, quads before a ray and a long result stall covered");
    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
